// ===== rtl/wsfc_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfc_pkg
// Shared sizes, hash constants, types and helpers of the flow counter.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfc_pkg;

    // BUCKET_COUNT is a power of two; the bucket is a field of the hash.
    localparam int BUCKET_COUNT     = 1024;
    localparam int CELLS_PER_BUCKET = 8;
    localparam int CELL_TOTAL       = BUCKET_COUNT * CELLS_PER_BUCKET;
    localparam int BUCKET_W         = $clog2(BUCKET_COUNT);
    localparam int SLOT_W           = (CELLS_PER_BUCKET > 1) ? $clog2(CELLS_PER_BUCKET) : 1;
    localparam int CELL_AW          = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;

    localparam logic [31:0] MURMUR_SEED = 32'd1324534127;
    localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2    = 32'h1b873593;
    localparam logic [31:0] MIX_ADD   = 32'he6546b64;
    localparam logic [31:0] FMIX_C1   = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2   = 32'hc2b2ae35;
    localparam logic [31:0] KEY_LEN   = 32'd13;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] port_pair;
        logic [7:0]  protocol;
    } key_t;

    typedef struct packed {
        key_t        key;
        logic [31:0] count;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    typedef enum logic [2:0] {
        ACT_FILL        = 3'd0,
        ACT_HIT_EXACT   = 3'd1,
        ACT_HIT_INEXACT = 3'd2,
        ACT_REPLACE     = 3'd3,
        ACT_REJECT      = 3'd4
    } action_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_SCAN,
        ST_DECIDE,
        ST_OLDHASH,
        ST_COMMIT,
        ST_RESULT
    } state_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int r);
        rotl32 = (v << r) | (v >> (32 - r));
    endfunction

    // Clamp a 34-bit signed sum to the 32-bit signed range.
    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            sat32 = 32'h7fffffff;
        else if (v < -34'sd2147483648)
            sat32 = 32'h80000000;
        else
            sat32 = v[31:0];
    endfunction

    // Magnitude of a signed count; the most negative value gives 2^31.
    function automatic logic [32:0] mag33(input logic [31:0] c);
        logic signed [32:0] s;
        s = {c[31], c};
        mag33 = c[31] ? 33'(-s) : 33'(s);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wsfc_ram.sv =====
// ----------------------------------------------------------------------------
// wsfc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/wsfc_hash.sv =====
// ----------------------------------------------------------------------------
// wsfc_hash
// Iterative 32-bit MurmurHash3 of a 13-byte flow key, one multiply a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfc_hash (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire wsfc_pkg::key_t key,
    output logic                done,
    output logic [31:0]         hash
);
    import wsfc_pkg::*;

    logic [3:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    key_t        key_reg;
    logic [31:0] k_reg;
    logic [31:0] h_reg;

    logic [31:0] blk;
    logic [31:0] hx;
    logic [31:0] tail;

    function automatic logic [31:0] bswap(input logic [31:0] v);
        bswap = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    always_comb
    begin
        case (step_reg[2:1])
            2'd0:    blk = bswap(key_reg.src_addr);
            2'd1:    blk = bswap(key_reg.dst_addr);
            2'd2:    blk = bswap(key_reg.port_pair);
            default: blk = {24'd0, key_reg.protocol};
        endcase
        hx   = rotl32(h_reg ^ k_reg, 13);
        tail = h_reg ^ k_reg ^ KEY_LEN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd9)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Steps 0-7 mix the four blocks; a block's h update rides with the
    // next block's first multiply. Steps 8-9 finish the avalanche.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= key;
            h_reg   <= MURMUR_SEED;
        end
        else if (busy_reg)
        begin
            if (step_reg < 4'd8)
            begin
                if (!step_reg[0])
                begin
                    if (step_reg != 4'd0)
                    begin
                        h_reg <= (hx << 2) + hx + MIX_ADD;
                    end
                    k_reg <= blk * MIX_C1;
                end
                else
                begin
                    k_reg <= rotl32(k_reg, 15) * MIX_C2;
                end
            end
            else if (step_reg == 4'd8)
            begin
                h_reg <= (tail ^ (tail >> 16)) * FMIX_C1;
            end
            else
            begin
                h_reg <= (h_reg ^ (h_reg >> 13)) * FMIX_C2;
            end
        end
    end

    assign done = done_reg;
    assign hash = h_reg ^ (h_reg >> 16);

endmodule

`default_nettype wire

// ===== rtl/waving_sketch_flow_counter_top.sv =====
// ----------------------------------------------------------------------------
// waving_sketch_flow_counter_top
// WavingSketch insert of IPv4 5-tuples over bucket and cell memories.
// ----------------------------------------------------------------------------
//  channel | signals                                              | dir
//  --------+------------------------------------------------------+----
//  in      | in_valid, in_ready, src_addr, dst_addr, sport,       | in
//          | dport, protocol                                      |
//  out     | out_valid, out_ready, action, bucket_index,           | out
//          | cell_slot, cell_value, waving_value                   |
//
//  One beat at a time: the key is hashed, then cells are read until a hit or an
//  empty cell; a full scan adds the decide and commit states, and replacing an
//  exact cell adds a second pass through the iterative hash unit.
//  After reset a clearing pass over all CELL_TOTAL (8192) cells zeroes both
//  memories; in_ready stays low during it. The result register frees the
//  input side: the next beat is taken while a result waits on out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module waving_sketch_flow_counter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] src_addr,
    input  wire logic [31:0] dst_addr,
    input  wire logic [15:0] sport,
    input  wire logic [15:0] dport,
    input  wire logic [7:0]  protocol,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       action,
    output logic [9:0]       bucket_index,
    output logic [2:0]       cell_slot,
    output logic signed [31:0] cell_value,
    output logic signed [31:0] waving_value
);
    import wsfc_pkg::*;

    localparam logic [CELL_AW-1:0] CPB       = CELL_AW'(CELLS_PER_BUCKET);
    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(CELLS_PER_BUCKET - 1);
    localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELL_TOTAL - 1);

    state_t                state_reg, state_next;
    key_t                  key_reg, key_next;
    logic [BUCKET_W-1:0]   bucket_reg, bucket_next;
    logic                  neg_reg, neg_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [32:0]           min_mag_reg, min_mag_next;
    logic [SLOT_W-1:0]     min_slot_reg, min_slot_next;
    cell_t                 min_cell_reg, min_cell_next;
    logic [31:0]           w_reg, w_next;
    logic                  admit_reg, admit_next;
    logic [CELL_AW-1:0]    clr_reg, clr_next;
    action_t               res_action_reg, res_action_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;
    logic [31:0]           res_cell_reg, res_cell_next;
    logic [31:0]           res_wave_reg, res_wave_next;
    logic                  out_valid_reg, out_valid_next;
    action_t               out_action_reg, out_action_next;
    logic [BUCKET_W-1:0]   out_bucket_reg, out_bucket_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic [31:0]           out_cell_reg, out_cell_next;
    logic [31:0]           out_wave_reg, out_wave_next;

    logic                  hash_start;
    key_t                  hash_key;
    logic                  hash_done;
    logic [31:0]           hash;

    logic                  cram_we;
    logic [CELL_AW-1:0]    cram_waddr, cram_raddr;
    cell_t                 cram_wdata, cell_rd;
    logic                  wram_we;
    logic [BUCKET_W-1:0]   wram_waddr;
    logic [31:0]           wram_wdata, w_cur;

    logic [CELL_AW-1:0]    base_addr, scan_addr;
    logic [32:0]           mag_j;
    logic signed [33:0]    w34, ws34, old34;
    logic [31:0]           step_w;
    key_t                  in_key;

    assign in_key    = '{src_addr, dst_addr, {sport, dport}, protocol};
    assign base_addr = CELL_AW'(bucket_reg) * CPB;
    assign scan_addr = base_addr + CELL_AW'(slot_reg);
    assign mag_j     = mag33(cell_rd.count);

    wsfc_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (hash_key),
        .done  (hash_done),
        .hash  (hash)
    );

    wsfc_ram #(.WIDTH(CELL_W), .DEPTH(CELL_TOTAL)) u_cell_ram (
        .clk   (clk),
        .we    (cram_we),
        .waddr (cram_waddr),
        .wdata (cram_wdata),
        .raddr (cram_raddr),
        .rdata (cell_rd)
    );

    // Waving counter of the current bucket sits on the read port throughout.
    wsfc_ram #(.WIDTH(32), .DEPTH(BUCKET_COUNT)) u_wave_ram (
        .clk   (clk),
        .we    (wram_we),
        .waddr (wram_waddr),
        .wdata (wram_wdata),
        .raddr (bucket_reg),
        .rdata (w_cur)
    );

    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        bucket_next     = bucket_reg;
        neg_next        = neg_reg;
        slot_next       = slot_reg;
        min_mag_next    = min_mag_reg;
        min_slot_next   = min_slot_reg;
        min_cell_next   = min_cell_reg;
        w_next          = w_reg;
        admit_next      = admit_reg;
        clr_next        = clr_reg;
        res_action_next = res_action_reg;
        res_slot_next   = res_slot_reg;
        res_cell_next   = res_cell_reg;
        res_wave_next   = res_wave_reg;
        out_valid_next  = out_valid_reg;
        out_action_next = out_action_reg;
        out_bucket_next = out_bucket_reg;
        out_slot_next   = out_slot_reg;
        out_cell_next   = out_cell_reg;
        out_wave_next   = out_wave_reg;

        in_ready   = 1'b0;
        hash_start = 1'b0;
        hash_key   = key_reg;
        cram_we    = 1'b0;
        cram_waddr = scan_addr;
        cram_wdata = cell_rd;
        cram_raddr = scan_addr + CELL_AW'(1);
        wram_we    = 1'b0;
        wram_waddr = bucket_reg;
        wram_wdata = w_cur;

        w34    = {{2{w_cur[31]}}, w_cur};
        ws34   = neg_reg ? -w34 : w34;
        old34  = {{2{min_cell_reg.count[31]}}, min_cell_reg.count};
        step_w = neg_reg ? sat32({{2{w_reg[31]}}, w_reg} - 34'sd1)
                         : sat32({{2{w_reg[31]}}, w_reg} + 34'sd1);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                cram_we    = 1'b1;
                cram_waddr = clr_reg;
                cram_wdata = '0;
                wram_we    = int'(clr_reg) < BUCKET_COUNT;
                wram_waddr = clr_reg[BUCKET_W-1:0];
                wram_wdata = '0;
                clr_next   = clr_reg + CELL_AW'(1);
                if (clr_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    key_next   = in_key;
                    hash_start = 1'b1;
                    hash_key   = in_key;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    bucket_next = hash[BUCKET_W:1];
                    neg_next    = hash[0];
                    slot_next   = '0;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cram_raddr = base_addr;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                res_slot_next = slot_reg;
                res_wave_next = w_cur;
                if (cell_rd.count == 32'd0)
                begin
                    cram_we         = 1'b1;
                    cram_wdata      = '{key_reg, 32'hffffffff};
                    res_action_next = ACT_FILL;
                    res_cell_next   = 32'hffffffff;
                    state_next      = ST_RESULT;
                end
                else if (cell_rd.key == key_reg)
                begin
                    cram_we = 1'b1;
                    if (cell_rd.count[31])
                    begin
                        cram_wdata.count = sat32({{2{cell_rd.count[31]}}, cell_rd.count}
                                                 - 34'sd1);
                        res_action_next  = ACT_HIT_EXACT;
                    end
                    else
                    begin
                        cram_wdata.count = sat32({2'b00, cell_rd.count} + 34'sd1);
                        wram_we          = 1'b1;
                        wram_wdata       = neg_reg ? sat32(w34 - 34'sd1)
                                                   : sat32(w34 + 34'sd1);
                        res_wave_next    = wram_wdata;
                        res_action_next  = ACT_HIT_INEXACT;
                    end
                    res_cell_next = cram_wdata.count;
                    state_next    = ST_RESULT;
                end
                else
                begin
                    // Strict less-than keeps the lowest slot on a tie.
                    if (slot_reg == '0 || mag_j < min_mag_reg)
                    begin
                        min_mag_next  = mag_j;
                        min_slot_next = slot_reg;
                        min_cell_next = cell_rd;
                    end
                    if (slot_reg == LAST_SLOT)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
            end
            ST_DECIDE:
            begin
                w_next     = w_cur;
                admit_next = ws34 >= $signed({1'b0, min_mag_reg});
                if ((ws34 >= $signed({1'b0, min_mag_reg})) && min_cell_reg.count[31])
                begin
                    hash_start = 1'b1;
                    hash_key   = min_cell_reg.key;
                    state_next = ST_OLDHASH;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_OLDHASH:
            begin
                // Fold the evicted exact count back in with its own sign.
                if (hash_done)
                begin
                    w_next = hash[0] ? sat32({{2{w_reg[31]}}, w_reg} + old34)
                                     : sat32({{2{w_reg[31]}}, w_reg} - old34);
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                wram_we       = 1'b1;
                wram_wdata    = step_w;
                res_wave_next = step_w;
                res_slot_next = min_slot_reg;
                cram_waddr    = base_addr + CELL_AW'(min_slot_reg);
                if (admit_reg)
                begin
                    cram_we         = 1'b1;
                    cram_wdata      = '{key_reg, sat32({1'b0, min_mag_reg} + 34'sd1)};
                    res_action_next = ACT_REPLACE;
                    res_cell_next   = cram_wdata.count;
                end
                else
                begin
                    res_action_next = ACT_REJECT;
                    res_cell_next   = min_cell_reg.count;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_action_next = res_action_reg;
                    out_bucket_next = bucket_reg;
                    out_slot_next   = res_slot_reg;
                    out_cell_next   = res_cell_reg;
                    out_wave_next   = res_wave_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        bucket_reg     <= bucket_next;
        neg_reg        <= neg_next;
        slot_reg       <= slot_next;
        min_mag_reg    <= min_mag_next;
        min_slot_reg   <= min_slot_next;
        min_cell_reg   <= min_cell_next;
        w_reg          <= w_next;
        admit_reg      <= admit_next;
        res_action_reg <= res_action_next;
        res_slot_reg   <= res_slot_next;
        res_cell_reg   <= res_cell_next;
        res_wave_reg   <= res_wave_next;
        out_action_reg <= out_action_next;
        out_bucket_reg <= out_bucket_next;
        out_slot_reg   <= out_slot_next;
        out_cell_reg   <= out_cell_next;
        out_wave_reg   <= out_wave_next;
    end

    assign out_valid    = out_valid_reg;
    assign action       = out_action_reg;
    assign bucket_index = 10'(out_bucket_reg);
    assign cell_slot    = 3'(out_slot_reg);
    assign cell_value   = out_cell_reg;
    assign waving_value = out_wave_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_waving_sketch_flow_counter_top.sv =====
// ----------------------------------------------------------------------------
// tb_waving_sketch_flow_counter_top
// Drives 5-tuples into the flow counter and checks every result beat against
// a behavioral WavingSketch insert with its own bucket and cell stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_waving_sketch_flow_counter_top;

    import wsfc_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_N    = 750;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
    } tuple_t;

    typedef struct packed {
        action_t     act;
        logic [9:0]  bucket;
        logic [2:0]  slot;
        logic [31:0] cnt_val;
        logic [31:0] waving;
    } verdict_t;

    typedef struct {
        tuple_t   tup;
        bit       has_fixed;
        verdict_t fixed;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  action;
    logic [9:0]  bucket_index;
    logic [2:0]  cell_slot;
    logic signed [31:0] cell_value;
    logic signed [31:0] waving_value;

    // sketch state mirror
    logic [31:0] wave_mem [BUCKET_COUNT];
    key_t        key_mem  [CELL_TOTAL];
    logic [31:0] cnt_mem  [CELL_TOTAL];

    verdict_t pending_q[$];
    tuple_t   flow_pool[$];
    row_t     rows[$];
    int       errors;
    bit       send_done;
    longint   cycles;

    waving_sketch_flow_counter_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .src_addr(src_addr), .dst_addr(dst_addr),
        .sport(sport), .dport(dport), .protocol(protocol),
        .out_valid(out_valid), .out_ready(out_ready),
        .action(action), .bucket_index(bucket_index), .cell_slot(cell_slot),
        .cell_value(cell_value), .waving_value(waving_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] rol(logic [31:0] v, int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble(logic [31:0] k);
        k = k * 32'hcc9e2d51;
        k = rol(k, 15);
        return k * 32'h1b873593;
    endfunction

    function automatic logic [31:0] swap_bytes(logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [31:0] murmur_key(key_t k);
        logic [31:0] h;
        h = 32'd1324534127;
        h ^= scramble(swap_bytes(k.src_addr));
        h = rol(h, 13) * 32'd5 + 32'he6546b64;
        h ^= scramble(swap_bytes(k.dst_addr));
        h = rol(h, 13) * 32'd5 + 32'he6546b64;
        h ^= scramble(swap_bytes(k.port_pair));
        h = rol(h, 13) * 32'd5 + 32'he6546b64;
        h ^= scramble({24'd0, k.protocol});
        h ^= 32'd13;
        h ^= h >> 16;
        h = h * 32'h85ebca6b;
        h ^= h >> 13;
        h = h * 32'hc2b2ae35;
        h ^= h >> 16;
        return h;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic longint to_s(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic key_t make_key(tuple_t t);
        key_t k;
        k.src_addr  = t.src_addr;
        k.dst_addr  = t.dst_addr;
        k.port_pair = {t.sport, t.dport};
        k.protocol  = t.protocol;
        return k;
    endfunction

    function automatic logic [9:0] bucket_of(tuple_t t);
        logic [31:0] h;
        h = murmur_key(make_key(t));
        return h[10:1];
    endfunction

    function automatic verdict_t sketch_insert(tuple_t t);
        verdict_t    r;
        key_t        k;
        logic [31:0] h;
        longint      sgn, w, v, m, min_m, old, osg;
        int          b, base, min_j, c;
        bit          done;
        k = make_key(t);
        h = murmur_key(k);
        sgn = h[0] ? -1 : 1;
        b = int'(h[10:1]);
        base = b * CELLS_PER_BUCKET;
        min_m = -1;
        min_j = 0;
        done = 0;
        r.act = ACT_REJECT;
        r.slot = 3'd0;
        for (int j = 0; j < CELLS_PER_BUCKET && !done; j++)
        begin
            c = base + j;
            if (cnt_mem[c] == 0)
            begin
                key_mem[c] = k;
                cnt_mem[c] = 32'hffffffff;
                r.act = ACT_FILL;
                r.slot = 3'(j);
                done = 1;
            end
            else if (key_mem[c] == k)
            begin
                v = to_s(cnt_mem[c]);
                if (v < 0)
                begin
                    cnt_mem[c] = clamp32(v - 1);
                    r.act = ACT_HIT_EXACT;
                end
                else
                begin
                    cnt_mem[c] = clamp32(v + 1);
                    wave_mem[b] = clamp32(to_s(wave_mem[b]) + sgn);
                    r.act = ACT_HIT_INEXACT;
                end
                r.slot = 3'(j);
                done = 1;
            end
            else
            begin
                v = to_s(cnt_mem[c]);
                m = (v < 0) ? -v : v;
                if (min_m < 0 || m < min_m)
                begin
                    min_m = m;
                    min_j = j;
                end
            end
        end
        if (!done)
        begin
            c = base + min_j;
            w = to_s(wave_mem[b]);
            r.slot = 3'(min_j);
            if (w * sgn >= min_m)
            begin
                old = to_s(cnt_mem[c]);
                if (old < 0)
                begin
                    osg = murmur_key(key_mem[c]) & 1 ? -1 : 1;
                    w = to_s(clamp32(w - osg * old));
                end
                key_mem[c] = k;
                cnt_mem[c] = clamp32(min_m + 1);
                r.act = ACT_REPLACE;
            end
            wave_mem[b] = clamp32(w + sgn);
        end
        r.bucket = 10'(b);
        r.cnt_val = cnt_mem[base + int'(r.slot)];
        r.waving = wave_mem[b];
        return r;
    endfunction

    function automatic tuple_t rand_tuple();
        tuple_t t;
        t.src_addr = $urandom;
        t.dst_addr = $urandom;
        t.sport    = 16'($urandom);
        t.dport    = 16'($urandom);
        t.protocol = 8'($urandom);
        return t;
    endfunction

    // Find a fresh tuple landing in the given bucket.
    function automatic tuple_t tuple_in_bucket(logic [9:0] b);
        tuple_t t;
        do
            t = rand_tuple();
        while (bucket_of(t) != b);
        return t;
    endfunction

    // Valid stays high across a zero gap; drop it only when idling.
    task automatic send_beat(tuple_t t, bit has_fixed, verdict_t fixed);
        verdict_t e;
        int       gap;
        gap = $urandom_range(0, 11);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        src_addr <= t.src_addr;
        dst_addr <= t.dst_addr;
        sport    <= t.sport;
        dport    <= t.dport;
        protocol <= t.protocol;
        do
            @(posedge clk);
        while (!in_ready);
        e = sketch_insert(t);
        if (has_fixed && e != fixed)
        begin
            $error("directed row prediction mismatch: expected %h got %h", fixed, e);
            errors++;
        end
        pending_q.push_back(e);
    endtask

    // sender
    initial
    begin
        tuple_t   t;
        row_t     rw;
        verdict_t none;
        tuple_t   hot[$];
        logic [9:0] hb;
        errors = 0;
        send_done = 0;
        none = '0;
        in_valid = 1'b0;
        src_addr = '0;
        dst_addr = '0;
        sport = '0;
        dport = '0;
        protocol = '0;
        for (int i = 0; i < BUCKET_COUNT; i++)
            wave_mem[i] = '0;
        for (int i = 0; i < CELL_TOTAL; i++)
        begin
            key_mem[i] = '0;
            cnt_mem[i] = '0;
        end
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: the all-zero key matches the reset key of an empty cell
        // but must still fill it; then extremes and a hit.
        t = '0;
        rw.tup = t;
        rw.has_fixed = 1;
        rw.fixed = '{ACT_FILL, bucket_of(t), 3'd0, 32'hffffffff, 32'd0};
        rows.push_back(rw);
        rw.fixed = '{ACT_HIT_EXACT, bucket_of(t), 3'd0, 32'hfffffffe, 32'd0};
        rows.push_back(rw);
        t = '1;
        rw.tup = t;
        rw.fixed = '{ACT_FILL, bucket_of(t), 3'd0, 32'hffffffff, 32'd0};
        rows.push_back(rw);
        rw.has_fixed = 0;
        t = '{32'h80000000, 32'h00000001, 16'h8000, 16'h0001, 8'h80};
        rw.tup = t;
        rows.push_back(rw);
        // Overfill one bucket: fills, then rejects and replacements.
        hb = bucket_of('1);
        for (int i = 0; i < 14; i++)
        begin
            rw.tup = tuple_in_bucket(hb);
            rows.push_back(rw);
        end
        foreach (rows[i])
            send_beat(rows[i].tup, rows[i].has_fixed, rows[i].fixed);
        @(negedge clk);
        in_valid <= 1'b0;

        // Hold off until the block has drained.
        wait (pending_q.size() == 0);

        // Random: mostly repeats of a hot set concentrated on a few buckets.
        for (int i = 0; i < 24; i++)
            hot.push_back(tuple_in_bucket(10'($urandom_range(0, 3))));
        for (int i = 0; i < RANDOM_N; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1:    t = rand_tuple();
                2, 3:    t = tuple_in_bucket(10'($urandom_range(0, 3)));
                default: t = hot[$urandom_range(0, hot.size() - 1)];
            endcase
            if (i % 100 == 50)
                t = (i % 200 == 50) ? tuple_t'('0) : tuple_t'('1);
            send_beat(t, 0, none);
        end
        @(negedge clk);
        in_valid <= 1'b0;
        send_done = 1;
    end

    // receiver and checker
    initial
    begin
        verdict_t e;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clk);
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_q.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (action !== e.act)
                begin
                    $error("action: expected %0d actual %0d", e.act, action);
                    errors++;
                end
                if (bucket_index !== e.bucket)
                begin
                    $error("bucket_index: expected %0d actual %0d", e.bucket, bucket_index);
                    errors++;
                end
                if (cell_slot !== e.slot)
                begin
                    $error("cell_slot: expected %0d actual %0d", e.slot, cell_slot);
                    errors++;
                end
                if (cell_value !== e.cnt_val)
                begin
                    $error("cell_value: expected %0d actual %0d",
                           $signed(e.cnt_val), cell_value);
                    errors++;
                end
                if (waving_value !== e.waving)
                begin
                    $error("waving_value: expected %0d actual %0d",
                           $signed(e.waving), waving_value);
                    errors++;
                end
            end
        end
    end

    // end of run and watchdog
    initial
    begin
        cycles = 0;
        while (!(send_done && pending_q.size() == 0) && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[waving_sketch_flow_counter_top] ERROR");
        end
        else
        begin
            repeat (60) @(posedge clk);
            if (errors == 0)
                $display("[waving_sketch_flow_counter_top] OK");
            else
                $display("[waving_sketch_flow_counter_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/wsfc_pkg.sv
rtl/wsfc_ram.sv
rtl/wsfc_hash.sv
rtl/waving_sketch_flow_counter_top.sv
tb/sv/tb_waving_sketch_flow_counter_top.sv
